// ===== rtl/core/csimd_pkg.sv =====
package csimd_pkg;

    // Table depth and derived widths
    localparam int NUM_SUBCARRIERS = 64;
    localparam int IDX_W = (NUM_SUBCARRIERS > 1) ? $clog2(NUM_SUBCARRIERS) : 1;
    localparam int CNT_W = $clog2(NUM_SUBCARRIERS + 1);

    // Amplitude and packet sum
    localparam int AMP_W = 16;
    localparam int SUM_W = 24;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam int PROD_W = AMP_W + CNT_W;
    localparam int CMP_W = (PROD_W > SUM_W) ? PROD_W : SUM_W;

    // Averaging weights, out of 256
    localparam int AVG_W = 24;
    localparam logic [AVG_W-1:0] AVG_KEEP = 24'd230;
    localparam logic [AVG_W-1:0] AVG_TAKE = 24'd26;

    // Square root: 16-bit radicand, two bits per step
    localparam int SQ_W = 16;
    localparam int SQRT_STEPS = 16;
    localparam int STEP_W = $clog2(SQRT_STEPS);
    localparam int REM_W = 18;

    // Configuration port
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_FLOOR = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS = 8'd3;

    localparam logic [CFG_DATA_W-1:0] RST_DIFF_THRESHOLD = 16'd307;
    localparam logic [CFG_DATA_W-1:0] RST_VALID_FLOOR = 16'd26;
    localparam logic [CFG_DATA_W-1:0] RST_HOLD_MS = 16'd2000;

    // Item kinds
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK = 1'b1;

endpackage

// ===== rtl/core/csi_motion_detector.sv =====
// Motion detector on channel-state amplitudes.
// Input channel (i_in_valid / o_in_ready): one item per transaction, either a
// subcarrier sample pair (op 0) or a millisecond tick (op 1).
// Output channel (o_out_valid / i_out_ready): exactly one result per input item,
// carrying the motion flag and the set / cleared strobes of that item.
// Config channel (i_cfg_valid / o_cfg_ready): always ready, one register write
// per transaction; write only while the block is idle.
// Steps: a sample in range runs 16 square-root steps in the shared two-bit root
// unit, then an accumulate and a hand-off; the table read overlaps the accept. A
// last pair adds the packet decision before the hand-off. A tick runs its hold
// check, then the hand-off; skipped pairs and items taken while disabled go
// straight to the hand-off, a skipped last pair through the packet decision.
// One item is in work at a time; a new item is taken the cycle after the result
// is loaded. The result sits in an output register, so a new item is taken
// while an earlier result still waits; if the receiver stalls, the block holds
// the next result until the register frees and accepts nothing more meanwhile.
// Reset clears the per-subcarrier averages (valid bits), the packet sum, the
// count, the motion flag and the detection time, and loads register defaults.
module csi_motion_detector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [csimd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [csimd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_op,
    input  logic signed [7:0]                   i_imag_part,
    input  logic signed [7:0]                   i_real_part,
    input  logic                                i_first_pair,
    input  logic                                i_last_pair,
    input  logic                                i_invalid_pair,
    input  logic [31:0]                         i_now_ms,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_motion,
    output logic                                o_motion_set,
    output logic                                o_motion_cleared
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_SQRT,
        ST_ACCUM,
        ST_MUL,
        ST_CMP,
        ST_DONE
    } t_state;

    t_state r_state;

    // Configuration
    logic                               r_enable;
    logic [csimd_pkg::CFG_DATA_W-1:0]   r_thr;
    logic [csimd_pkg::CFG_DATA_W-1:0]   r_floor;
    logic [csimd_pkg::CFG_DATA_W-1:0]   r_hold;

    // Packet state; the subcarrier index and pair count always move together
    logic [csimd_pkg::SUM_W-1:0]        r_sum;
    logic [csimd_pkg::CNT_W-1:0]        r_cnt;
    logic                               r_motion;
    logic [31:0]                        r_detect;

    // Item in work
    logic                               r_last;
    logic [31:0]                        r_now;
    logic                               r_set;
    logic                               r_clr;

    // Root unit
    logic [csimd_pkg::SQ_W-1:0]         r_rad;
    logic [csimd_pkg::REM_W-1:0]        r_rem;
    logic [csimd_pkg::AMP_W-1:0]        r_root;
    logic [csimd_pkg::STEP_W-1:0]       r_step;

    logic [csimd_pkg::PROD_W-1:0]       r_prod;

    // Average table
    logic [csimd_pkg::AMP_W-1:0]        r_avg_mem [csimd_pkg::NUM_SUBCARRIERS];
    logic [csimd_pkg::NUM_SUBCARRIERS-1:0] r_avg_vld;
    logic [csimd_pkg::AMP_W-1:0]        r_rd_data;
    logic                               r_rd_vld;

    // Output register
    logic                               r_out_valid;
    logic                               r_out_motion;
    logic                               r_out_set;
    logic                               r_out_clr;

    // Combinational terms
    logic                               n_accept;
    logic [csimd_pkg::CNT_W-1:0]        n_cnt_base;
    logic                               n_in_range;
    logic                               n_do_pair;
    logic [csimd_pkg::IDX_W-1:0]        n_rd_idx;
    logic [csimd_pkg::IDX_W-1:0]        n_wr_idx;
    logic                               n_wr_en;
    logic signed [csimd_pkg::SQ_W-1:0]  n_im_ext;
    logic signed [csimd_pkg::SQ_W-1:0]  n_re_ext;
    logic [csimd_pkg::SQ_W-1:0]         n_sq;
    logic [csimd_pkg::REM_W+1:0]        n_rem_sh;
    logic [csimd_pkg::REM_W+1:0]        n_trial;
    logic                               n_take;
    logic [csimd_pkg::AMP_W-1:0]        n_avg;
    logic [csimd_pkg::AMP_W-1:0]        n_diff;
    logic [csimd_pkg::SUM_W:0]          n_sum_ext;
    logic [csimd_pkg::SUM_W-1:0]        n_sum_sat;
    logic [csimd_pkg::AVG_W-1:0]        n_avg_mix;
    logic [csimd_pkg::AMP_W-1:0]        n_avg_new;
    logic [31:0]                        n_elapsed;
    logic                               n_out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign n_accept    = i_in_valid && o_in_ready;
    assign n_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_cnt_base = i_first_pair ? '0 : r_cnt;
        n_in_range = n_cnt_base < csimd_pkg::CNT_W'(csimd_pkg::NUM_SUBCARRIERS);
        n_do_pair  = n_accept && r_enable && (i_op == csimd_pkg::OP_SAMPLE)
                     && !i_invalid_pair && n_in_range;
        n_rd_idx   = n_cnt_base[csimd_pkg::IDX_W-1:0];
        n_wr_idx   = r_cnt[csimd_pkg::IDX_W-1:0];
        n_wr_en    = (r_state == ST_ACCUM);

        // 8x8 squares, summed; at most 2 * 128^2
        n_im_ext = csimd_pkg::SQ_W'(i_imag_part);
        n_re_ext = csimd_pkg::SQ_W'(i_real_part);
        n_sq     = n_im_ext * n_im_ext + n_re_ext * n_re_ext;

        // One restoring root step
        n_rem_sh = {r_rem, r_rad[csimd_pkg::SQ_W-1 -: 2]};
        n_trial  = {2'b00, r_root, 2'b01};
        n_take   = n_rem_sh >= n_trial;

        n_avg     = r_rd_vld ? r_rd_data : '0;
        n_diff    = (r_root > n_avg) ? (r_root - n_avg) : (n_avg - r_root);
        n_sum_ext = {1'b0, r_sum} + (csimd_pkg::SUM_W + 1)'(n_diff);
        n_sum_sat = n_sum_ext[csimd_pkg::SUM_W] ? csimd_pkg::SUM_MAX
                                                 : n_sum_ext[csimd_pkg::SUM_W-1:0];
        n_avg_mix = csimd_pkg::AVG_W'(n_avg) * csimd_pkg::AVG_KEEP
                  + csimd_pkg::AVG_W'(r_root) * csimd_pkg::AVG_TAKE;
        n_avg_new = n_avg_mix[csimd_pkg::AVG_W-1 -: csimd_pkg::AMP_W];

        n_elapsed = r_now - r_detect;
    end

    // Average table: one read, one write port
    always_ff @(posedge i_clk) begin
        if (n_do_pair) begin
            r_rd_data <= r_avg_mem[n_rd_idx];
        end
        if (n_wr_en) begin
            r_avg_mem[n_wr_idx] <= n_avg_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (n_do_pair) begin
                r_rd_vld <= r_avg_vld[n_rd_idx];
            end
            if (n_wr_en) begin
                r_avg_vld[n_wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_enable     <= 1'b0;
            r_thr        <= csimd_pkg::RST_DIFF_THRESHOLD;
            r_floor      <= csimd_pkg::RST_VALID_FLOOR;
            r_hold       <= csimd_pkg::RST_HOLD_MS;
            r_sum        <= '0;
            r_cnt        <= '0;
            r_motion     <= 1'b0;
            r_detect     <= '0;
            r_set        <= 1'b0;
            r_clr        <= 1'b0;
            r_step       <= '0;
            r_out_valid  <= 1'b0;
            r_out_motion <= 1'b0;
            r_out_set    <= 1'b0;
            r_out_clr    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    csimd_pkg::CFG_ENABLE:         r_enable <= i_cfg_data[0];
                    csimd_pkg::CFG_DIFF_THRESHOLD: r_thr    <= i_cfg_data;
                    csimd_pkg::CFG_VALID_FLOOR:    r_floor  <= i_cfg_data;
                    csimd_pkg::CFG_HOLD_MS:        r_hold   <= i_cfg_data;
                    default: ;
                endcase
            end

            // in ST_DONE the hand-off below owns the output register
            if (r_out_valid && i_out_ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (n_accept) begin
                        r_last <= i_last_pair;
                        r_now  <= i_now_ms;
                        r_set  <= 1'b0;
                        r_clr  <= 1'b0;
                        if (!r_enable) begin
                            r_state <= ST_DONE;
                        end else if (i_op == csimd_pkg::OP_TICK) begin
                            r_state <= ST_TICK;
                        end else begin
                            if (i_first_pair) begin
                                r_sum <= '0;
                                r_cnt <= '0;
                            end
                            if (!i_invalid_pair && n_in_range) begin
                                r_rad   <= n_sq;
                                r_rem   <= '0;
                                r_root  <= '0;
                                r_step  <= csimd_pkg::STEP_W'(csimd_pkg::SQRT_STEPS - 1);
                                r_state <= ST_SQRT;
                            end else if (i_last_pair) begin
                                r_state <= ST_MUL;
                            end else begin
                                r_state <= ST_DONE;
                            end
                        end
                    end
                end
                ST_TICK: begin
                    if (r_motion && (n_elapsed > 32'(r_hold))) begin
                        r_motion <= 1'b0;
                        r_clr    <= 1'b1;
                    end
                    r_state <= ST_DONE;
                end
                ST_SQRT: begin
                    r_rad  <= {r_rad[csimd_pkg::SQ_W-3:0], 2'b00};
                    r_rem  <= n_take ? csimd_pkg::REM_W'(n_rem_sh - n_trial)
                                     : csimd_pkg::REM_W'(n_rem_sh);
                    r_root <= {r_root[csimd_pkg::AMP_W-2:0], n_take};
                    r_step <= r_step - csimd_pkg::STEP_W'(1);
                    if (r_step == '0) begin
                        r_state <= ST_ACCUM;
                    end
                end
                ST_ACCUM: begin
                    if (n_avg > r_floor) begin
                        r_sum <= n_sum_sat;
                    end
                    r_cnt   <= r_cnt + csimd_pkg::CNT_W'(1);
                    r_state <= r_last ? ST_MUL : ST_DONE;
                end
                ST_MUL: begin
                    r_prod  <= csimd_pkg::PROD_W'(r_thr) * csimd_pkg::PROD_W'(r_cnt);
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if ((r_cnt != '0) && (csimd_pkg::CMP_W'(r_sum) > csimd_pkg::CMP_W'(r_prod)))
                    begin
                        r_motion <= 1'b1;
                        r_detect <= r_now;
                        r_set    <= 1'b1;
                    end
                    // a last mark always restarts the packet
                    r_sum   <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (n_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_motion <= r_motion;
                        r_out_set    <= r_set;
                        r_out_clr    <= r_clr;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_motion         = r_out_motion;
    assign o_motion_set     = r_out_set;
    assign o_motion_cleared = r_out_clr;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= csimd_pkg::CNT_W'(csimd_pkg::NUM_SUBCARRIERS))
        else $error("pair count beyond table depth");

    a_set_has_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_motion_set |-> o_motion && !o_motion_cleared)
        else $error("motion declared but flag low");

    a_clr_no_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_motion_cleared |-> !o_motion)
        else $error("motion cleared but flag high");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE && r_out_valid && !i_out_ready |=> r_state == ST_DONE)
        else $error("result overwritten while receiver stalls");
`endif

endmodule
